// ===== hdl/cbu_pkg.sv =====
// shared constants and types of the camera basis pipeline
package cbu_pkg;

	localparam int MAG_W    = 30;
	localparam int SUM_W    = 62;
	localparam int ROOT_W   = 31;
	localparam int NUM_W    = 61;
	localparam int SQ_STEPS = 31;
	localparam int DV_STEPS = 31;

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;

	typedef logic [31:0] comp_t;
	typedef comp_t [2:0] vec_t;
	typedef logic [63:0] wide_t;
	typedef wide_t [2:0] wvec_t;

	typedef enum logic [1:0] {
		VIEW_GEN  = 2'd0,
		VIEW_DOWN = 2'd1,
		VIEW_UP   = 2'd2
	} view_t;

	// travels beside the vector data through the normalizers
	typedef struct packed {
		view_t view;
		logic  degen;
		vec_t  w;
		vec_t  u;
	} tag_t;

endpackage

// ===== hdl/cbu_setup_if.sv =====
// camera setup channel: eye, look-at point and up vector
interface cbu_setup_if;
	logic        valid;
	logic        ready;
	logic [31:0] eye_x;
	logic [31:0] eye_y;
	logic [31:0] eye_z;
	logic [31:0] target_x;
	logic [31:0] target_y;
	logic [31:0] target_z;
	logic [31:0] up_x;
	logic [31:0] up_y;
	logic [31:0] up_z;

	modport source (
		output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
		input  ready
	);
	modport sink (
		input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
		output ready
	);
endinterface

// ===== hdl/cbu_basis_if.sv =====
// basis result channel: u, v, w in Q1.30 and the degenerate flag
interface cbu_basis_if;
	logic        valid;
	logic        ready;
	logic [31:0] u_x;
	logic [31:0] u_y;
	logic [31:0] u_z;
	logic [31:0] v_x;
	logic [31:0] v_y;
	logic [31:0] v_z;
	logic [31:0] w_x;
	logic [31:0] w_y;
	logic [31:0] w_z;
	logic        degenerate;

	modport source (
		output valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z, degenerate,
		input  ready
	);
	modport sink (
		input  valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z, degenerate,
		output ready
	);
endinterface

// ===== hdl/cbu_front.sv =====
// front pipeline: view difference, range reduction and up x view cross product
module cbu_front
	import cbu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	cbu_setup_if.sink  setup,
	output logic       valid_o,
	output wvec_t      dr_o,
	output wvec_t      t_o,
	output tag_t       tag_o
);

	logic [2:0][31:0] eye, tgt, upv;
	logic [2:0][32:0] dcomb;
	view_t            view_c;

	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [2:0][32:0] d_s1;
	logic [2:0][31:0] up_s1, up_s2, up_s3;
	view_t            view_s1, view_s2, view_s3, view_s4, view_s5;
	logic [2:0][32:0] mag_s2;
	logic [2:0]       neg_s2, neg_s3;
	logic [32:0]      orw_s2;
	logic [2:0][29:0] drm_s3;
	logic [2:0][30:0] dr_s4;
	logic [5:0][62:0] p_s4;
	wvec_t            dr_s5, t_s5;

	logic [1:0]       sh;
	logic [2:0][32:0] shm;
	logic [2:0][30:0] drs;
	logic [5:0][62:0] prod;

	assign setup.ready = adv;

	always_comb begin
		eye = {setup.eye_z, setup.eye_y, setup.eye_x};
		tgt = {setup.target_z, setup.target_y, setup.target_x};
		upv = {setup.up_z, setup.up_y, setup.up_x};
		for (int i = 0; i < 3; i++)
			dcomb[i] = {eye[i][31], eye[i]} - {tgt[i][31], tgt[i]};
		view_c = VIEW_GEN;
		if (eye[0] == tgt[0] && eye[2] == tgt[2]) begin
			if ($signed(eye[1]) > $signed(tgt[1]))
				view_c = VIEW_DOWN;
			else if ($signed(eye[1]) < $signed(tgt[1]))
				view_c = VIEW_UP;
		end
	end

	// common right shift that brings the largest magnitude below 2^30
	always_comb begin
		if (orw_s2[32])
			sh = 2'd3;
		else if (orw_s2[31])
			sh = 2'd2;
		else if (orw_s2[30])
			sh = 2'd1;
		else
			sh = 2'd0;
		for (int i = 0; i < 3; i++)
			shm[i] = mag_s2[i] >> sh;
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			drs[i] = neg_s3[i] ? 31'(-{1'b0, drm_s3[i]}) : {1'b0, drm_s3[i]};
		prod[0] = 63'($signed(up_s3[1]) * $signed(drs[2]));
		prod[1] = 63'($signed(up_s3[2]) * $signed(drs[1]));
		prod[2] = 63'($signed(up_s3[2]) * $signed(drs[0]));
		prod[3] = 63'($signed(up_s3[0]) * $signed(drs[2]));
		prod[4] = 63'($signed(up_s3[0]) * $signed(drs[1]));
		prod[5] = 63'($signed(up_s3[1]) * $signed(drs[0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= setup.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1    <= dcomb;
			up_s1   <= upv;
			view_s1 <= view_c;

			for (int i = 0; i < 3; i++) begin
				neg_s2[i] <= d_s1[i][32];
				mag_s2[i] <= d_s1[i][32] ? 33'(-d_s1[i]) : d_s1[i];
			end
			orw_s2  <= (d_s1[0][32] ? 33'(-d_s1[0]) : d_s1[0])
				| (d_s1[1][32] ? 33'(-d_s1[1]) : d_s1[1])
				| (d_s1[2][32] ? 33'(-d_s1[2]) : d_s1[2]);
			up_s2   <= up_s1;
			view_s2 <= view_s1;

			for (int i = 0; i < 3; i++)
				drm_s3[i] <= shm[i][29:0];
			neg_s3  <= neg_s2;
			up_s3   <= up_s2;
			view_s3 <= view_s2;

			dr_s4   <= drs;
			p_s4    <= prod;
			view_s4 <= view_s3;

			for (int i = 0; i < 3; i++)
				dr_s5[i] <= {{33{dr_s4[i][30]}}, dr_s4[i]};
			t_s5[0] <= {p_s4[0][62], p_s4[0]} - {p_s4[1][62], p_s4[1]};
			t_s5[1] <= {p_s4[2][62], p_s4[2]} - {p_s4[3][62], p_s4[3]};
			t_s5[2] <= {p_s4[4][62], p_s4[4]} - {p_s4[5][62], p_s4[5]};
			view_s5 <= view_s4;
		end
	end

	assign valid_o = valid_s5;
	assign dr_o    = dr_s5;
	assign t_o     = t_s5;

	always_comb begin
		tag_o       = '0;
		tag_o.view  = view_s5;
		tag_o.degen = 1'b0;
	end

endmodule

// ===== hdl/cbu_norm.sv =====
// vector normalizer: prescale, sum of squares, pipelined square root and divides
module cbu_norm
	import cbu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  valid_i,
	input  wvec_t vec_i,
	input  tag_t  tag_i,
	output logic  valid_o,
	output vec_t  vec_o,
	output logic  zero_o,
	output tag_t  tag_o
);

	typedef struct packed {
		logic                  zero;
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
		tag_t                  tag;
	} side_t;

	// prescale stages
	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0][63:0]      mag_s1, mag_s2;
	logic [2:0]            neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]           orw_s1;
	tag_t                  tag_s1, tag_s2, tag_s3, tag_s4;
	logic                  right_s2;
	logic [5:0]            amt_s2;
	logic [2:0][MAG_W-1:0] mag_s3, mag_s4;
	logic [2:0][59:0]      sq_s4;

	logic [6:0]            blen;
	logic                  right_c;
	logic [5:0]            amt_c;
	logic [2:0][63:0]      shv;
	logic [SUM_W-1:0]      sum_c;

	// square root, one result bit per stage
	logic                  sq_v_s    [SQ_STEPS+1];
	side_t                 sq_side_s [SQ_STEPS+1];
	logic [SUM_W-1:0]      sq_rem_s  [SQ_STEPS+1];
	logic [ROOT_W-1:0]     sq_root_s [SQ_STEPS+1];
	logic [SUM_W:0]        sq_trial  [SQ_STEPS];
	logic [SUM_W-1:0]      sq_nrem   [SQ_STEPS];
	logic [ROOT_W-1:0]     sq_nroot  [SQ_STEPS];

	// three restoring dividers, one quotient bit per stage
	logic                         dv_v_s    [DV_STEPS+1];
	side_t                        dv_side_s [DV_STEPS+1];
	logic [ROOT_W-1:0]            dv_len_s  [DV_STEPS+1];
	logic [2:0][NUM_W-1:0]        dv_num_s  [DV_STEPS+1];
	logic [2:0][ROOT_W-1:0]       dv_rem_s  [DV_STEPS+1];
	logic [2:0][DV_STEPS-1:0]     dv_q_s    [DV_STEPS+1];
	logic [2:0][ROOT_W-1:0]       dv_nrem   [DV_STEPS];
	logic [2:0][DV_STEPS-1:0]     dv_nq     [DV_STEPS];
	logic [2:0][NUM_W-1:0]        num_c;

	logic                  valid_s6;
	vec_t                  vec_s6;
	logic                  zero_s6;
	tag_t                  tag_s6;
	vec_t                  res_c;

	// shift that puts the largest magnitude into [2^29, 2^30)
	always_comb begin
		blen = '0;
		for (int b = 0; b < 64; b++)
			if (orw_s1[b])
				blen = 7'(b + 1);
		right_c = blen > 7'd30;
		if (right_c)
			amt_c = 6'(blen - 7'd30);
		else if (blen != 7'd0)
			amt_c = 6'(7'd30 - blen);
		else
			amt_c = 6'd0;
		for (int i = 0; i < 3; i++)
			shv[i] = right_s2 ? (mag_s2[i] >> amt_s2) : (mag_s2[i] << amt_s2);
		sum_c = SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
	end

	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			sq_trial[k] = ((SUM_W + 1)'(sq_root_s[k]) << (SQ_STEPS - k))
				+ ((SUM_W + 1)'(1) << (2 * (SQ_STEPS - 1 - k)));
			if ({1'b0, sq_rem_s[k]} >= sq_trial[k]) begin
				sq_nrem[k]  = SUM_W'({1'b0, sq_rem_s[k]} - sq_trial[k]);
				sq_nroot[k] = sq_root_s[k] | (ROOT_W'(1) << (SQ_STEPS - 1 - k));
			end else begin
				sq_nrem[k]  = sq_rem_s[k];
				sq_nroot[k] = sq_root_s[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			num_c[i] = (NUM_W'(sq_side_s[SQ_STEPS].mag[i]) << 30)
				+ NUM_W'(sq_root_s[SQ_STEPS] >> 1);
		for (int j = 0; j < DV_STEPS; j++) begin
			for (int i = 0; i < 3; i++) begin
				logic [ROOT_W:0] r2;
				r2 = {dv_rem_s[j][i], dv_num_s[j][i][DV_STEPS - 1 - j]};
				if (r2 >= {1'b0, dv_len_s[j]}) begin
					dv_nrem[j][i] = ROOT_W'(r2 - {1'b0, dv_len_s[j]});
					dv_nq[j][i]   = dv_q_s[j][i] | (DV_STEPS'(1) << (DV_STEPS - 1 - j));
				end else begin
					dv_nrem[j][i] = r2[ROOT_W-1:0];
					dv_nq[j][i]   = dv_q_s[j][i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [31:0] q;
			q = {1'b0, dv_q_s[DV_STEPS][i]};
			if (q > Q30_ONE)
				q = Q30_ONE;
			if (dv_side_s[DV_STEPS].zero)
				res_c[i] = '0;
			else
				res_c[i] = dv_side_s[DV_STEPS].neg[i] ? -q : q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s6 <= 1'b0;
			for (int k = 0; k <= SQ_STEPS; k++)
				sq_v_s[k] <= 1'b0;
			for (int j = 0; j <= DV_STEPS; j++)
				dv_v_s[j] <= 1'b0;
		end else if (adv) begin
			valid_s1  <= valid_i;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			sq_v_s[0] <= valid_s4;
			for (int k = 0; k < SQ_STEPS; k++)
				sq_v_s[k+1] <= sq_v_s[k];
			dv_v_s[0] <= sq_v_s[SQ_STEPS];
			for (int j = 0; j < DV_STEPS; j++)
				dv_v_s[j+1] <= dv_v_s[j];
			valid_s6  <= dv_v_s[DV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec_i[i][63];
				mag_s1[i] <= vec_i[i][63] ? 64'(-vec_i[i]) : vec_i[i];
			end
			orw_s1 <= (vec_i[0][63] ? 64'(-vec_i[0]) : vec_i[0])
				| (vec_i[1][63] ? 64'(-vec_i[1]) : vec_i[1])
				| (vec_i[2][63] ? 64'(-vec_i[2]) : vec_i[2]);
			tag_s1 <= tag_i;

			mag_s2   <= mag_s1;
			neg_s2   <= neg_s1;
			right_s2 <= right_c;
			amt_s2   <= amt_c;
			tag_s2   <= tag_s1;

			for (int i = 0; i < 3; i++)
				mag_s3[i] <= shv[i][MAG_W-1:0];
			neg_s3 <= neg_s2;
			tag_s3 <= tag_s2;

			for (int i = 0; i < 3; i++)
				sq_s4[i] <= 60'(mag_s3[i]) * 60'(mag_s3[i]);
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			tag_s4 <= tag_s3;

			sq_rem_s[0]       <= sum_c;
			sq_root_s[0]      <= '0;
			sq_side_s[0].zero <= sum_c == '0;
			sq_side_s[0].neg  <= neg_s4;
			sq_side_s[0].mag  <= mag_s4;
			sq_side_s[0].tag  <= tag_s4;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_rem_s[k+1]  <= sq_nrem[k];
				sq_root_s[k+1] <= sq_nroot[k];
				sq_side_s[k+1] <= sq_side_s[k];
			end

			dv_side_s[0] <= sq_side_s[SQ_STEPS];
			dv_len_s[0]  <= sq_root_s[SQ_STEPS];
			dv_num_s[0]  <= num_c;
			dv_q_s[0]    <= '0;
			for (int i = 0; i < 3; i++)
				dv_rem_s[0][i] <= {1'b0, num_c[i][NUM_W-1:DV_STEPS]};
			for (int j = 0; j < DV_STEPS; j++) begin
				dv_side_s[j+1] <= dv_side_s[j];
				dv_len_s[j+1]  <= dv_len_s[j];
				dv_num_s[j+1]  <= dv_num_s[j];
				dv_rem_s[j+1]  <= dv_nrem[j];
				dv_q_s[j+1]    <= dv_nq[j];
			end

			vec_s6  <= res_c;
			zero_s6 <= dv_side_s[DV_STEPS].zero;
			tag_s6  <= dv_side_s[DV_STEPS].tag;
		end
	end

	assign valid_o = valid_s6;
	assign vec_o   = vec_s6;
	assign zero_o  = zero_s6;
	assign tag_o   = tag_s6;

endmodule

// ===== hdl/camera_basis_uvw.sv =====
// camera basis top level: front, w and u normalizers, w x u, v normalizer, output register
//
// Takes one camera setup per cycle and returns its orthonormal basis (u, v, w) in Q1.30
// through 5 front stages, 69 stages in each of the two normalizers in series (31 square
// root stages and 31 divide stages set most of that), 2 cross product stages and the
// output register. Straight-down and straight-up views give the fixed bases; a zero view
// or an up vector parallel to it raises degenerate and zeroes the vectors. While a result
// waits on the output the whole pipeline holds, so nothing is lost or repeated; with the
// output taken every cycle the rate is one transaction per cycle.
module camera_basis_uvw
	import cbu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cbu_setup_if.sink   setup,
	cbu_basis_if.source basis
);

	logic  adv;
	logic  fr_valid;
	wvec_t fr_dr, fr_t;
	tag_t  fr_tag;

	logic  nw_valid, nw_zero, nu_zero;
	vec_t  nw_vec, nu_vec;
	tag_t  nw_tag;

	logic             valid_x1, valid_x2;
	tag_t             tag_x1, tag_x2;
	logic [5:0][63:0] p_x1;
	wvec_t            t_x2;

	logic  nv_valid;
	vec_t  nv_vec;
	logic  nv_zero;
	tag_t  nv_tag;

	logic  out_valid_q;
	vec_t  u_q, v_q, w_q;
	logic  degen_q;
	vec_t  u_c, v_c, w_c;
	logic  degen_c;
	tag_t  tag_c;

	assign adv = !out_valid_q || basis.ready;

	cbu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.setup   (setup),
		.valid_o (fr_valid),
		.dr_o    (fr_dr),
		.t_o     (fr_t),
		.tag_o   (fr_tag)
	);

	cbu_norm u_norm_w (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (fr_valid),
		.vec_i   (fr_dr),
		.tag_i   (fr_tag),
		.valid_o (nw_valid),
		.vec_o   (nw_vec),
		.zero_o  (nw_zero),
		.tag_o   (nw_tag)
	);

	cbu_norm u_norm_u (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (fr_valid),
		.vec_i   (fr_t),
		.tag_i   (fr_tag),
		.valid_o (),
		.vec_o   (nu_vec),
		.zero_o  (nu_zero),
		.tag_o   ()
	);

	always_comb begin
		tag_c       = nw_tag;
		tag_c.degen = nw_zero || nu_zero;
		tag_c.w     = nw_vec;
		tag_c.u     = nu_vec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_x1    <= 1'b0;
			valid_x2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_x1    <= nw_valid;
			valid_x2    <= valid_x1;
			out_valid_q <= nv_valid;
		end
	end

	// w x u
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_x1  <= tag_c;
			p_x1[0] <= 64'($signed(nw_vec[1]) * $signed(nu_vec[2]));
			p_x1[1] <= 64'($signed(nw_vec[2]) * $signed(nu_vec[1]));
			p_x1[2] <= 64'($signed(nw_vec[2]) * $signed(nu_vec[0]));
			p_x1[3] <= 64'($signed(nw_vec[0]) * $signed(nu_vec[2]));
			p_x1[4] <= 64'($signed(nw_vec[0]) * $signed(nu_vec[1]));
			p_x1[5] <= 64'($signed(nw_vec[1]) * $signed(nu_vec[0]));

			tag_x2  <= tag_x1;
			t_x2[0] <= p_x1[0] - p_x1[1];
			t_x2[1] <= p_x1[2] - p_x1[3];
			t_x2[2] <= p_x1[4] - p_x1[5];
		end
	end

	cbu_norm u_norm_v (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (valid_x2),
		.vec_i   (t_x2),
		.tag_i   (tag_x2),
		.valid_o (nv_valid),
		.vec_o   (nv_vec),
		.zero_o  (nv_zero),
		.tag_o   (nv_tag)
	);

	always_comb begin
		u_c     = '0;
		v_c     = '0;
		w_c     = '0;
		degen_c = 1'b0;
		case (nv_tag.view)
			VIEW_DOWN: begin
				u_c[2] = Q30_ONE;
				v_c[0] = Q30_ONE;
				w_c[1] = Q30_ONE;
			end
			VIEW_UP: begin
				u_c[0] = Q30_ONE;
				v_c[2] = Q30_ONE;
				w_c[1] = -Q30_ONE;
			end
			default: begin
				if (nv_tag.degen) begin
					degen_c = 1'b1;
				end else begin
					u_c = nv_tag.u;
					w_c = nv_tag.w;
					// v of a unit pair is never zero; keep zero if it ever is
					v_c = nv_zero ? '0 : nv_vec;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_q     <= u_c;
			v_q     <= v_c;
			w_q     <= w_c;
			degen_q <= degen_c;
		end
	end

	assign basis.valid      = out_valid_q;
	assign basis.u_x        = u_q[0];
	assign basis.u_y        = u_q[1];
	assign basis.u_z        = u_q[2];
	assign basis.v_x        = v_q[0];
	assign basis.v_y        = v_q[1];
	assign basis.v_z        = v_q[2];
	assign basis.w_x        = w_q[0];
	assign basis.w_y        = w_q[1];
	assign basis.w_z        = w_q[2];
	assign basis.degenerate = degen_q;

endmodule
